### hdl/fpda_pkg.sv
// ----------------------------------------------------------------------------
// fpda_pkg
// Shared constants and types for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package fpda_pkg;

  localparam int VALUE_W          = 32;
  localparam int NDIG_W           = 3;
  localparam int CHAR_W           = 8;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAX_FRAC_DEF     = 4;
  // Integer part never exceeds 2^31, so ten decimal digits cover it.
  localparam int INT_DIGITS       = 10;
  localparam int BCD_W            = 4 * INT_DIGITS;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef logic [3:0] digit_t;

endpackage

### hdl/fpda_if.sv
// ----------------------------------------------------------------------------
// fpda_in_if / fpda_out_if
// Valid/ready channels carrying input numbers and output characters.
// ----------------------------------------------------------------------------
interface fpda_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpda_pkg::VALUE_W-1:0] value;
  logic [fpda_pkg::NDIG_W-1:0]         frac_digits;
  modport source (output valid, value, frac_digits, input ready);
  modport sink   (input valid, value, frac_digits, output ready);
endinterface

interface fpda_out_if;
  logic                         valid;
  logic                         ready;
  logic [fpda_pkg::CHAR_W-1:0]  char_out;
  logic                         last;
  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

### hdl/fpda_conv.sv
// ----------------------------------------------------------------------------
// fpda_conv
// Pipelined binary to BCD conversion (double dabble), four bits per stage, and
// fraction digits alongside. One number may enter each cycle unless stalled.
// ----------------------------------------------------------------------------
module fpda_conv #(
  parameter int FRAC_BITS       = fpda_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = fpda_pkg::MAX_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [fpda_pkg::VALUE_W-1:0]           in_value,
  input  logic [fpda_pkg::NDIG_W-1:0]            in_ndig,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_neg,
  output logic [fpda_pkg::BCD_W-1:0]             out_bcd,
  output logic [4*MAX_FRAC_DIGITS-1:0]           out_frac,
  output logic [fpda_pkg::NDIG_W-1:0]            out_ndig
);
  localparam int INT_W    = fpda_pkg::VALUE_W - FRAC_BITS;
  localparam int BITS_PER = 4;
  localparam int STAGES   = (INT_W + BITS_PER - 1) / BITS_PER;
  localparam int FSTEP    = (MAX_FRAC_DIGITS + STAGES - 1) / STAGES;
  localparam int FW       = FRAC_BITS + 4;
  localparam int BW       = fpda_pkg::BCD_W;
  localparam int IPAD     = STAGES * BITS_PER;

  // Stage 0 registers: sign, magnitude split.
  logic                  v0;
  logic                  neg0;
  logic [IPAD-1:0]       ip0;
  logic [FRAC_BITS-1:0]  fr0;
  logic [fpda_pkg::NDIG_W-1:0] nd0;

  logic                  v   [STAGES];
  logic                  ng  [STAGES];
  logic [IPAD-1:0]       ip  [STAGES];
  logic [BW-1:0]         bcd [STAGES];
  logic [FRAC_BITS-1:0]  fr  [STAGES];
  logic [4*MAX_FRAC_DIGITS-1:0] fd [STAGES];
  logic [fpda_pkg::NDIG_W-1:0]  nd [STAGES];

  logic adv [STAGES+1];
  logic [fpda_pkg::VALUE_W-1:0] mag;
  logic neg_in;

  // A stage advances when its downstream neighbor is free or advancing.
  assign adv[STAGES] = out_ready || !v[STAGES-1];
  assign in_ready    = !v0 || adv[0];
  assign adv[0]      = !v[0] || adv[1];

  assign neg_in = in_value[fpda_pkg::VALUE_W-1];
  assign mag    = neg_in ? (~in_value + 1'b1) : in_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (in_ready) begin
      v0 <= in_valid;
    end
    if (in_ready) begin
      neg0 <= neg_in;
      ip0  <= IPAD'(mag[fpda_pkg::VALUE_W-1:FRAC_BITS]);
      fr0  <= mag[FRAC_BITS-1:0];
      nd0  <= (in_ndig > fpda_pkg::NDIG_W'(MAX_FRAC_DIGITS))
              ? fpda_pkg::NDIG_W'(MAX_FRAC_DIGITS) : in_ndig;
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                 pv;
    logic                 png;
    logic [IPAD-1:0]      pip;
    logic [BW-1:0]        pbcd;
    logic [FRAC_BITS-1:0] pfr;
    logic [4*MAX_FRAC_DIGITS-1:0] pfd;
    logic [fpda_pkg::NDIG_W-1:0]  pnd;
    logic [IPAD-1:0]      nip;
    logic [BW-1:0]        nbcd;
    logic [FRAC_BITS-1:0] nfr;
    logic [4*MAX_FRAC_DIGITS-1:0] nfd;

    if (s == 0) begin : g_src0
      assign pv = v0; assign png = neg0; assign pip = ip0;
      assign pbcd = '0; assign pfr = fr0; assign pfd = '0; assign pnd = nd0;
    end else begin : g_srcn
      assign pv = v[s-1]; assign png = ng[s-1]; assign pip = ip[s-1];
      assign pbcd = bcd[s-1]; assign pfr = fr[s-1]; assign pfd = fd[s-1];
      assign pnd = nd[s-1];
    end

    always_comb begin
      logic [FW-1:0] prod;
      nbcd = pbcd;
      nip  = pip;
      nfr  = pfr;
      nfd  = pfd;
      prod = '0;
      for (int b = 0; b < BITS_PER; b++) begin
        for (int d = 0; d < fpda_pkg::INT_DIGITS; d++) begin
          if (nbcd[4*d +: 4] >= 4'd5) nbcd[4*d +: 4] = nbcd[4*d +: 4] + 4'd3;
        end
        nbcd = {nbcd[BW-2:0], nip[IPAD-1]};
        nip  = {nip[IPAD-2:0], 1'b0};
      end
      for (int k = 0; k < FSTEP; k++) begin
        if (s * FSTEP + k < MAX_FRAC_DIGITS) begin
          prod = {nfr, 3'b000} + {2'b00, nfr, 1'b0};
          nfd[4*(MAX_FRAC_DIGITS-1-(s*FSTEP+k)) +: 4] = prod[FW-1:FRAC_BITS];
          nfr = prod[FRAC_BITS-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv[s+1] || !v[s]) begin
        v[s] <= pv;
      end
      if (adv[s+1] || !v[s]) begin
        ng[s] <= png; ip[s] <= nip; bcd[s] <= nbcd;
        fr[s] <= nfr; fd[s] <= nfd; nd[s] <= pnd;
      end
    end
    if (s > 0) begin : g_adv
      assign adv[s] = !v[s] || adv[s+1];
    end
  end

  assign out_valid = v[STAGES-1];
  assign out_neg   = ng[STAGES-1];
  assign out_bcd   = bcd[STAGES-1];
  assign out_frac  = fd[STAGES-1];
  assign out_ndig  = nd[STAGES-1];
endmodule

### hdl/fpda_emit.sv
// ----------------------------------------------------------------------------
// fpda_emit
// Serializes one converted number into characters, one per cycle while the
// receiver does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
module fpda_emit #(
  parameter int MAX_FRAC_DIGITS = fpda_pkg::MAX_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_neg,
  input  logic [fpda_pkg::BCD_W-1:0]    in_bcd,
  input  logic [4*MAX_FRAC_DIGITS-1:0]  in_frac,
  input  logic [fpda_pkg::NDIG_W-1:0]   in_ndig,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpda_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);
  localparam int ND = fpda_pkg::INT_DIGITS;
  localparam int IW = $clog2(ND);
  localparam int FW = $clog2(MAX_FRAC_DIGITS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SIGN, S_INT, S_POINT, S_FRAC} state_t;

  state_t state;
  logic [fpda_pkg::BCD_W-1:0]   bcd;
  logic [4*MAX_FRAC_DIGITS-1:0] frac;
  logic [fpda_pkg::NDIG_W-1:0]  ndig;
  logic [IW-1:0] ipos;
  logic [FW-1:0] fpos;
  logic [IW-1:0] top;
  logic          ld;
  logic          slot;
  logic [3:0]    dig;

  // Index of the most significant nonzero integer digit (zero if none).
  always_comb begin
    top = '0;
    for (int d = 0; d < ND; d++) begin
      if (in_bcd[4*d +: 4] != 4'd0) top = IW'(d);
    end
  end

  assign slot     = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && slot;
  assign ld       = in_valid && in_ready;
  assign dig      = bcd[4*ipos +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (slot) out_valid <= 1'b0;
          if (ld) begin
            bcd   <= in_bcd;
            frac  <= in_frac;
            ndig  <= in_ndig;
            ipos  <= top;
            fpos  <= '0;
            state <= in_neg ? S_SIGN : S_INT;
          end
        end
        S_SIGN: if (slot) begin
          out_valid <= 1'b1;
          out_char  <= fpda_pkg::CH_MINUS;
          out_last  <= 1'b0;
          state     <= S_INT;
        end
        S_INT: if (slot) begin
          out_valid <= 1'b1;
          out_char  <= fpda_pkg::CH_ZERO + fpda_pkg::CHAR_W'(dig);
          out_last  <= (ipos == '0) && (ndig == '0);
          if (ipos != '0) ipos <= ipos - 1'b1;
          else state <= (ndig == '0) ? S_IDLE : S_POINT;
        end
        S_POINT: if (slot) begin
          out_valid <= 1'b1;
          out_char  <= fpda_pkg::CH_POINT;
          out_last  <= 1'b0;
          state     <= S_FRAC;
        end
        S_FRAC: if (slot) begin
          out_valid <= 1'b1;
          out_char  <= fpda_pkg::CH_ZERO +
                       fpda_pkg::CHAR_W'(frac[4*MAX_FRAC_DIGITS-1 -: 4]);
          out_last  <= (fpda_pkg::NDIG_W'(fpos) + 1'b1 == ndig);
          frac      <= frac << 4;
          fpos      <= fpos + 1'b1;
          if (fpda_pkg::NDIG_W'(fpos) + 1'b1 == ndig) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/fixed_point_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_ascii
// Converts a signed fixed-point number into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage: a word on the input channel carries value (two's complement with
// FRAC_BITS fraction bits) and frac_digits (0 prints the integer part only;
// counts above MAX_FRAC_DIGITS are clipped). Each number produces a run of
// words on the output channel, one character each, most significant first:
// an optional '-', the integer digits (a single '0' for a zero integer part),
// then '.' and the truncated fraction digits. The final character has last set.
// The front end is a pipeline, one stage per four integer bits (four stages at
// the default format), that turns the integer part into packed BCD and
// computes the fraction digits by repeated multiply by ten. A serializer then
// emits one character per cycle, while the receiver does not stall, after a
// load step, so a number takes 1 to 11 characters at the default format. The
// pipeline accepts new numbers while the serializer works.
// Reset clears all valid bits. When the receiver stalls, the output word is
// held and the stages fill up and then hold, losing nothing.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_ascii #(
  parameter int FRAC_BITS       = fpda_pkg::FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = fpda_pkg::MAX_FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fpda_in_if.sink    in_ch,
  fpda_out_if.source out_ch
);
  logic                         c_valid;
  logic                         c_ready;
  logic                         c_neg;
  logic [fpda_pkg::BCD_W-1:0]   c_bcd;
  logic [4*MAX_FRAC_DIGITS-1:0] c_frac;
  logic [fpda_pkg::NDIG_W-1:0]  c_ndig;

  // Conversion pipeline.
  fpda_conv #(.FRAC_BITS(FRAC_BITS), .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_conv (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_value(in_ch.value), .in_ndig(in_ch.frac_digits),
    .out_valid(c_valid), .out_ready(c_ready),
    .out_neg(c_neg), .out_bcd(c_bcd), .out_frac(c_frac), .out_ndig(c_ndig)
  );

  // Character serializer with its output register.
  fpda_emit #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_emit (
    .clk(clk), .rst(rst),
    .in_valid(c_valid), .in_ready(c_ready),
    .in_neg(c_neg), .in_bcd(c_bcd), .in_frac(c_frac), .in_ndig(c_ndig),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_char(out_ch.char_out), .out_last(out_ch.last)
  );

`ifndef SYNTHESIS
  // A stalled output word must not change under the serializer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.char_out))
    else $error("output word changed while stalled");
  // Characters are only digits, '-' or '.'.
  a_char: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.char_out == fpda_pkg::CH_MINUS ||
      out_ch.char_out == fpda_pkg::CH_POINT ||
      (out_ch.char_out >= fpda_pkg::CH_ZERO && out_ch.char_out <= 8'h39)))
    else $error("illegal character");
  // A point is never the final character.
  a_point: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.char_out == fpda_pkg::CH_POINT |-> !out_ch.last)
    else $error("text ends in a point");
`endif
endmodule

### tb/fixed_point_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_ascii_tb
// Self-checking bench for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
// A table of directed numbers covers the extremes of value and frac_digits,
// the sign of small negative values, the most negative value and clipping of
// large digit counts. A few rows carry their expected text typed in; every
// other row, and the random numbers that follow, is checked against a local
// predictor. Both channels idle at random so that gaps fall on every phase of
// the serializer.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpda_pkg::*;

  localparam int FRAC_BITS  = FRAC_BITS_DEF;
  localparam int MAX_DIGITS = MAX_FRAC_DEF;
  localparam int N_RANDOM   = 350;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [NDIG_W-1:0]  ndig;
    string              text;   // empty: use the predictor
  } stim_row_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_word_t;

  logic clk;
  logic rst;
  fpda_in_if  in_ch ();
  fpda_out_if out_ch ();

  fixed_point_to_decimal_ascii DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Characters still owed by the block, oldest first.
  char_word_t pending_chars[$];
  int         n_fail;
  int         n_cycles;
  bit         stim_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Decimal text of a fixed-point number, as the block should print it.
  function automatic string format_fixed(logic [VALUE_W-1:0] raw, logic [NDIG_W-1:0] nd);
    logic [31:0] mag;
    logic [31:0] ipart;
    logic [63:0] frac;
    string       digits;
    string       s;
    int          cnt;
    mag   = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
    ipart = mag >> FRAC_BITS;
    frac  = 64'(mag & ((32'd1 << FRAC_BITS) - 1));
    s     = raw[VALUE_W-1] ? "-" : "";
    digits = "";
    do begin
      digits = {string'(8'(CH_ZERO + ipart % 10)), digits};
      ipart  = ipart / 10;
    end while (ipart != 0);
    s   = {s, digits};
    cnt = (nd > MAX_DIGITS) ? MAX_DIGITS : int'(nd);
    if (cnt != 0) begin
      s = {s, string'(CH_POINT)};
      for (int k = 0; k < cnt; k++) begin
        frac = frac * 10;
        s    = {s, string'(8'(CH_ZERO + (frac >> FRAC_BITS)))};
        frac = frac & ((64'd1 << FRAC_BITS) - 1);
      end
    end
    return s;
  endfunction

  function automatic void queue_text(string s);
    char_word_t w;
    for (int k = 0; k < s.len(); k++) begin
      w.ch   = s[k];
      w.last = (k == s.len() - 1);
      pending_chars.push_back(w);
    end
  endfunction

  // Random values weighted toward small magnitudes, fraction edges and extremes.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      2:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3:       return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                           : 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 20000)) - 10000) * 65536
                      + $urandom_range(0, 65535);
    endcase
  endfunction

  // Sender: one number per accepted word, with random gaps. Valid drops only
  // when a gap follows, so back-to-back words keep it high.
  task automatic send_number(logic [VALUE_W-1:0] v, logic [NDIG_W-1:0] nd, string text);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.value       <= v;
    in_ch.frac_digits <= nd;
    queue_text(text.len() != 0 ? text : format_fixed(v, nd));
    do @(posedge clk); while (!in_ch.ready);
  endtask

  stim_row_t directed[] = '{
    '{32'h0000_0000, 3'd0, "0"},
    '{32'h0000_0000, 3'd4, "0.0000"},
    '{32'h0001_0000, 3'd0, "1"},
    '{32'hFFFF_0000, 3'd0, "-1"},
    '{32'h0000_8000, 3'd1, "0.5"},
    '{32'hFFFF_8000, 3'd2, "-0.50"},
    '{32'hFFFF_FFFF, 3'd2, "-0.00"},
    '{32'h0000_0001, 3'd4, "0.0000"},
    '{32'h0000_1000, 3'd4, "0.0625"},
    '{32'h7FFF_FFFF, 3'd4, "32767.9999"},
    '{32'h8000_0000, 3'd4, "-32768.0000"},
    '{32'h8000_0001, 3'd4, ""},
    '{32'h7FFF_FFFF, 3'd7, ""},
    '{32'h0003_243F, 3'd5, ""},
    '{32'h0003_243F, 3'd6, ""},
    '{32'hFFFC_DBC1, 3'd3, ""},
    '{32'h000A_0000, 3'd1, ""},
    '{32'h2710_FFFF, 3'd4, ""},
    '{32'hD8F0_0001, 3'd2, ""},
    '{32'h5555_AAAA, 3'd3, ""},
    '{32'hAAAA_5555, 3'd1, ""}
  };

  // Stimulus. Reset is held at the start and then released for good.
  initial begin
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.value       <= '0;
    in_ch.frac_digits <= '0;
    stim_done         = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_number(directed[i].value, directed[i].ndig, directed[i].text);
    for (int i = 0; i < N_RANDOM; i++)
      send_number(pick_value(), 3'($urandom_range(0, 7)), "");
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, with long stretches where ready stays high.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2);
      end
    end
  end

  // Checker: every accepted character is compared with the oldest one owed.
  always @(posedge clk) begin
    char_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: char_out %h last %b", out_ch.char_out, out_ch.last);
        n_fail++;
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.char_out !== want.ch) begin
          $error("char_out: expected %h actual %h", want.ch, out_ch.char_out);
          n_fail++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %b actual %b", want.last, out_ch.last);
          n_fail++;
        end
      end
    end
  end

  // End of run: drain, allow a quiet tail for stray words, then report.
  initial begin
    n_cycles = 0;
    n_fail   = 0;
    fork
      begin
        wait (stim_done);
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_fail == 0)
          $display("tb: success");
        else
          $display("tb: failure");
        $finish;
      end
      begin
        while (n_cycles < CYCLE_CAP) begin
          @(posedge clk);
          n_cycles++;
        end
        $display("tb: failure");
        $finish;
      end
    join
  end

endmodule

### fixed_point_to_decimal_ascii.f
hdl/fpda_pkg.sv
hdl/fpda_if.sv
hdl/fpda_conv.sv
hdl/fpda_emit.sv
hdl/fixed_point_to_decimal_ascii.sv
tb/fixed_point_to_decimal_ascii_tb.sv
